// File: sv/tbc24_pkg.sv
// tbc24_pkg: shared types, tables and GF(2^8) helpers for the 24-bit tweakable cipher.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package tbc24_pkg;

	localparam int unsigned BLK_W    = 24;
	localparam int unsigned KEY_W    = 64;
	localparam int unsigned NUM_RK   = 11;
	localparam int unsigned ROUNDS   = 10;
	// two key stages, one key-finish stage, then one stage per round
	localparam int unsigned LATENCY  = ROUNDS + 3;
	localparam logic [8:0]  POLY     = 9'h11b;

	localparam logic OP_ENC = 1'b0;
	localparam logic OP_DEC = 1'b1;

	typedef enum logic [0:0] {
		REG_KEY_HIGH = 1'b0,
		REG_KEY_LOW  = 1'b1
	} reg_idx_t;

	typedef logic [BLK_W-1:0] rkey_t;
	typedef rkey_t [NUM_RK-1:0] rkeys_t;
	typedef logic [7:0] byte_tab_t [256];

	typedef struct packed {
		logic dec;
		logic skip_mix;
		logic last_dec;
	} round_ctl_t;

	function automatic logic [7:0] rol8(input logic [7:0] v, input int unsigned n);
		logic [15:0] d;
		d = {v, v} << n;
		return d[15:8];
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] x;
		logic [7:0] r;
		x = {1'b0, a};
		r = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i])
				r = r ^ x[7:0];
			x = {x[7:0], 1'b0};
			if (x[8])
				x = x ^ POLY;
		end
		return r;
	endfunction

	// a^254, zero maps to zero
	function automatic logic [7:0] gf_inv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] p;
		logic [7:0] e;
		r = 8'h01;
		p = a;
		e = 8'd254;
		for (int i = 0; i < 8; i++) begin
			if (e[i])
				r = gf_mul(r, p);
			p = gf_mul(p, p);
		end
		return r;
	endfunction

	function automatic byte_tab_t build_sbox();
		byte_tab_t t;
		logic [7:0] b;
		for (int i = 0; i < 256; i++) begin
			b = gf_inv(8'(i));
			t[i] = b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
		end
		return t;
	endfunction

	function automatic byte_tab_t build_sbox_rev();
		byte_tab_t t;
		logic [7:0] s;
		logic [7:0] b;
		for (int i = 0; i < 256; i++) begin
			s = 8'(i);
			b = rol8(s, 1) ^ rol8(s, 3) ^ rol8(s, 6) ^ 8'h05;
			t[i] = gf_inv(b);
		end
		return t;
	endfunction

	localparam byte_tab_t SBOX     = build_sbox();
	localparam byte_tab_t SBOX_REV = build_sbox_rev();

	function automatic logic [BLK_W-1:0] sub_word(input logic [BLK_W-1:0] w, input logic inv);
		logic [BLK_W-1:0] r;
		for (int i = 0; i < 3; i++)
			r[8*i +: 8] = inv ? SBOX_REV[w[8*i +: 8]] : SBOX[w[8*i +: 8]];
		return r;
	endfunction

	function automatic logic [BLK_W-1:0] rot_word(input logic [BLK_W-1:0] w, input logic inv);
		return {w[23:16], inv ? rol8(w[15:8], 2) : rol8(w[15:8], 6), rol8(w[7:0], 4)};
	endfunction

	function automatic logic [BLK_W-1:0] mix_word(input logic [BLK_W-1:0] w,
			input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] m2);
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] c;
		a = w[23:16];
		b = w[15:8];
		c = w[7:0];
		return {gf_mul(m0, a) ^ gf_mul(m1, b) ^ gf_mul(m2, c),
			gf_mul(m2, a) ^ gf_mul(m0, b) ^ gf_mul(m1, c),
			gf_mul(m1, a) ^ gf_mul(m2, b) ^ gf_mul(m0, c)};
	endfunction

	function automatic logic [31:0] g_func(input logic [31:0] w, input logic [7:0] rc);
		return {SBOX[w[23:16]] ^ rc, SBOX[w[15:8]], SBOX[w[7:0]], SBOX[w[31:24]]};
	endfunction

endpackage

`default_nettype wire

// File: sv/tbc24_round.sv
// tbc24_round: one cipher round, forward or inverse, purely combinational.
// Depends on tbc24_pkg (S-box tables, rotate, column mix).
`timescale 1ns / 1ps
`default_nettype none

module tbc24_round import tbc24_pkg::*; (
	input  wire round_ctl_t        ctl,
	input  wire logic [BLK_W-1:0]  st_in,
	input  wire logic [BLK_W-1:0]  rk,
	input  wire logic [BLK_W-1:0]  rk_first,
	output logic      [BLK_W-1:0]  st_out
);

	logic [BLK_W-1:0] enc_rot;
	logic [BLK_W-1:0] enc_res;
	logic [BLK_W-1:0] dec_mix;
	logic [BLK_W-1:0] dec_sub;
	logic [BLK_W-1:0] dec_res;

	always_comb begin
		enc_rot = rot_word(sub_word(st_in, 1'b0), 1'b0);
		enc_res = (ctl.skip_mix ? enc_rot : mix_word(enc_rot, 8'd9, 8'd1, 8'd2)) ^ rk;

		dec_mix = ctl.skip_mix ? (st_in ^ rk) : mix_word(st_in ^ rk, 8'd6, 8'd8, 8'd39);
		dec_sub = sub_word(rot_word(dec_mix, 1'b1), 1'b1);
		dec_res = ctl.last_dec ? (dec_sub ^ rk_first) : dec_sub;

		st_out = ctl.dec ? dec_res : enc_res;
	end

endmodule

`default_nettype wire

// File: sv/tweakable_block_cipher_24_top.sv
// tweakable_block_cipher_24_top: pipelined 24-bit tweakable block cipher, 128-bit key.
// Depends on tbc24_pkg and tbc24_round.
//
// Usage:
//   Key: write key_high (index 0) and key_low (index 1) through the cfg_valid /
//   cfg_ready channel; cfg_ready is always high. Write only while no request
//   is in flight.
//   Requests: drive kind (0 encrypt, 1 decrypt), block_in and tweak with start.
//   A request is taken on every edge with start high and busy low; busy stays
//   low, so one request can be issued every cycle.
//   Results: block_out is valid for the single cycle in which done is high,
//   and results come out in request order.
//   Pipeline: a stage that XORs the tweak into the key, a key-schedule
//   stage (one S-box layer), a stage that completes the last round key (one
//   S-box layer), then one stage per round (ten rounds).
//   Throughput is one request per cycle.
//   The receiver cannot stall; it must take each result in its done cycle.
//   Reset (arst_n low) clears both key registers to zero and drops every
//   request in flight.
`timescale 1ns / 1ps
`default_nettype none

module tweakable_block_cipher_24_top import tbc24_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic              kind,
	input  wire logic [BLK_W-1:0]  block_in,
	input  wire logic [KEY_W-1:0]  tweak,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire reg_idx_t          cfg_index,
	input  wire logic [KEY_W-1:0]  cfg_data,
	output logic                   done,
	output logic      [BLK_W-1:0]  block_out
);

	logic [KEY_W-1:0] key_high_q;
	logic [KEY_W-1:0] key_low_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_KEY_LOW:  key_low_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: tweaked key
	logic             v_s1;
	logic             kind_s1;
	logic [BLK_W-1:0] blk_s1;
	logic [KEY_W-1:0] hi_s1;
	logic [KEY_W-1:0] lo_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1 <= kind;
			blk_s1  <= block_in;
			hi_s1   <= key_high_q ^ tweak;
			lo_s1   <= key_low_q;
		end
	end

	// stage 2: first g step, round keys 0..9
	logic [31:0]      g1;
	logic [KEY_W-1:0] h_a;
	logic [KEY_W-1:0] h_b;
	logic [KEY_W-1:0] l_a;
	logic [KEY_W-1:0] l_b;
	rkeys_t           rk_nxt;

	always_comb begin
		g1  = g_func(lo_s1[31:0], 8'h01);
		h_a = hi_s1 ^ {g1, 32'h0};
		h_b = {h_a[63:32], h_a[31:0] ^ h_a[63:32]};
		l_a = lo_s1 ^ {h_b[31:0], 32'h0};
		l_b = {l_a[63:32], l_a[31:0] ^ l_a[63:32]};
		rk_nxt[0]  = hi_s1[63:40];
		rk_nxt[1]  = hi_s1[39:16];
		rk_nxt[2]  = {hi_s1[15:0], lo_s1[63:56]};
		rk_nxt[3]  = lo_s1[55:32];
		rk_nxt[4]  = lo_s1[31:8];
		rk_nxt[5]  = {lo_s1[7:0], h_b[63:48]};
		rk_nxt[6]  = h_b[47:24];
		rk_nxt[7]  = h_b[23:0];
		rk_nxt[8]  = l_b[63:40];
		rk_nxt[9]  = l_b[39:16];
		rk_nxt[10] = '0;
	end

	logic             v_s2;
	logic             kind_s2;
	logic [BLK_W-1:0] blk_s2;
	rkeys_t           rk_s2;
	logic [15:0]      l16_s2;
	logic [7:0]       h8_s2;
	logic [31:0]      lw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s2 <= 1'b0;
		else
			v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		kind_s2 <= kind_s1;
		blk_s2  <= blk_s1;
		rk_s2   <= rk_nxt;
		l16_s2  <= l_b[15:0];
		h8_s2   <= h_b[63:56];
		lw_s2   <= l_b[31:0];
	end

	// stage 3: second g step, round key 10, initial whitening for encrypt
	logic [31:0] g2;
	rkeys_t      rk_full;

	always_comb begin
		g2 = g_func(lw_s2, 8'h02);
		rk_full     = rk_s2;
		rk_full[10] = {l16_s2, h8_s2 ^ g2[31:24]};
	end

	logic             rv_s   [ROUNDS+1];
	logic             rkind_s[ROUNDS+1];
	logic [BLK_W-1:0] rblk_s [ROUNDS+1];
	rkeys_t           rrk_s  [ROUNDS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			rv_s[0] <= 1'b0;
		else
			rv_s[0] <= v_s2;
	end

	always_ff @(posedge clk) begin
		rkind_s[0] <= kind_s2;
		rblk_s[0]  <= (kind_s2 == OP_DEC) ? blk_s2 : (blk_s2 ^ rk_full[0]);
		rrk_s[0]   <= rk_full;
	end

	// one stage per round
	for (genvar j = 1; j <= ROUNDS; j++) begin : g_round
		round_ctl_t       ctl;
		logic [BLK_W-1:0] rk_sel;
		logic [BLK_W-1:0] st_nxt;

		always_comb begin
			ctl.dec      = (rkind_s[j-1] == OP_DEC);
			ctl.skip_mix = (rkind_s[j-1] == OP_DEC) ? (j == 1) : (j == ROUNDS);
			ctl.last_dec = (rkind_s[j-1] == OP_DEC) && (j == ROUNDS);
			rk_sel       = (rkind_s[j-1] == OP_DEC) ? rrk_s[j-1][NUM_RK-j] : rrk_s[j-1][j];
		end

		tbc24_round u_round (
			.ctl      (ctl),
			.st_in    (rblk_s[j-1]),
			.rk       (rk_sel),
			.rk_first (rrk_s[j-1][0]),
			.st_out   (st_nxt)
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				rv_s[j] <= 1'b0;
			else
				rv_s[j] <= rv_s[j-1];
		end

		always_ff @(posedge clk) begin
			rkind_s[j] <= rkind_s[j-1];
			rblk_s[j]  <= st_nxt;
			rrk_s[j]   <= rrk_s[j-1];
		end
	end

	assign done      = rv_s[ROUNDS];
	assign block_out = rblk_s[ROUNDS];

endmodule

`default_nettype wire

// File: sv/tbc24_checker.sv
// tbc24_checker: port-level checks on request/result timing and the config handshake of the cipher top.
// Depends on tbc24_pkg; bound to tweakable_block_cipher_24_top below.
`timescale 1ns / 1ps
`default_nettype none

module tbc24_checker import tbc24_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire logic cfg_valid,
	input wire logic cfg_ready
);

	wire req = start && !busy;

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		req |-> ##LATENCY done)
		else $error("request without result at fixed latency");

	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(req, LATENCY))
		else $error("result without matching request");

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised on a full-rate pipeline");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write held off");

endmodule

bind tweakable_block_cipher_24_top tbc24_checker u_tbc24_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire
